[rtl/core/ipv4_header_receive_check_unit_macros.svh]
// ----------------------------------------------------------------------------
// IPv4 header receive check - assertion macros
// Shared concurrent assertion helpers; empty bodies under synthesis.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_RECEIVE_CHECK_UNIT_MACROS_SVH
`define IPV4_HEADER_RECEIVE_CHECK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define IPV4HC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ipv4hc assertion failed");
`define IPV4HC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipv4hc assertion failed");
`define IPV4HC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipv4hc assertion failed");
`else
`define IPV4HC_ASSERT(lbl, clk, rst_n, prop)
`define IPV4HC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IPV4HC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/ipv4hc_pkg.sv]
// ----------------------------------------------------------------------------
// IPv4 header receive check - package
// Shared types and constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipv4hc_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned OutDataW = 136;

  localparam logic [3:0] LAST_INDEX = 4'd9;
  localparam logic [3:0] IDLE_INDEX = 4'd10;

  localparam logic [3:0]  IP_VERSION    = 4'h4;
  localparam logic [3:0]  IHL_NO_OPTS   = 4'h5;
  localparam logic [15:0] MIN_TOTAL_LEN = 16'd20;
  localparam logic [15:0] CSUM_GOOD     = 16'hFFFF;
  localparam logic [31:0] BCAST_ADDR    = 32'hFFFF_FFFF;

  localparam logic REG_HOST_ADDR = 1'b0;
  localparam logic REG_HOST_MASK = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_DELIVER  = 2'd0,
    VERDICT_FRAGMENT = 2'd1,
    VERDICT_BAD      = 2'd2,
    VERDICT_NOT_MINE = 2'd3
  } verdict_e;

  typedef struct packed {
    logic        fmt_ok;
    logic [7:0]  protocol_num;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] packet_len;
    logic [15:0] ident;
    logic [13:0] frag_field;
    logic [7:0]  hop_limit;
  } hdr_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[rtl/core/ipv4hc_front.sv]
// ----------------------------------------------------------------------------
// IPv4 header receive check - front end
// Counts header words, keeps fields and the running ones-complement sum,
// and queues a parsed record on the tenth word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv4_header_receive_check_unit_macros.svh"

module ipv4hc_front
  import ipv4hc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [15:0]   word_i,
  input  logic          first_i,
  input  queue_status_t q_status_i,
  output logic          push_o,
  output hdr_rec_t      rec_o
);

  logic [3:0]  idx_q, idx_d;
  logic [15:0] sum_q, sum_d;
  logic        hdr_fmt_q;
  logic [15:0] len_q;
  logic [15:0] ident_q;
  logic [13:0] frag_q;
  logic [15:0] ttl_proto_q;
  logic        csum_nz_q;
  logic [15:0] src_hi_q;
  logic [15:0] src_lo_q;
  logic [15:0] dst_hi_q;

  logic [3:0]  eff_idx;
  logic        accept;
  logic        take;
  logic [15:0] sum_in;
  logic [16:0] sum_raw;

  assign in_ready_o = !((idx_q == LAST_INDEX) && q_status_i.full);
  assign accept     = in_valid_i && in_ready_o;
  assign eff_idx    = first_i ? 4'd0 : idx_q;
  assign take       = accept && (eff_idx != IDLE_INDEX);
  assign push_o     = take && (eff_idx == LAST_INDEX);

  // end-around carry add
  assign sum_in  = (eff_idx == 4'd0) ? 16'd0 : sum_q;
  assign sum_raw = {1'b0, sum_in} + {1'b0, word_i};
  assign sum_d   = sum_raw[15:0] + {15'd0, sum_raw[16]};

  assign idx_d = take ? (eff_idx + 4'd1) : (accept ? eff_idx : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
      sum_q <= 16'd0;
    end else begin
      idx_q <= idx_d;
      if (take) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      unique case (eff_idx)
        4'd0: hdr_fmt_q   <= (word_i[15:12] == IP_VERSION) && (word_i[11:8] == IHL_NO_OPTS);
        4'd1: len_q       <= word_i;
        4'd2: ident_q     <= word_i;
        4'd3: frag_q      <= word_i[13:0];
        4'd4: ttl_proto_q <= word_i;
        4'd5: csum_nz_q   <= (word_i != 16'd0);
        4'd6: src_hi_q    <= word_i;
        4'd7: src_lo_q    <= word_i;
        4'd8: dst_hi_q    <= word_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    rec_o.fmt_ok       = hdr_fmt_q && (len_q >= MIN_TOTAL_LEN)
                         && (!csum_nz_q || (sum_d == CSUM_GOOD));
    rec_o.protocol_num = ttl_proto_q[7:0];
    rec_o.src_addr     = {src_hi_q, src_lo_q};
    rec_o.dst_addr     = {dst_hi_q, word_i};
    rec_o.packet_len   = len_q;
    rec_o.ident        = ident_q;
    rec_o.frag_field   = frag_q;
    rec_o.hop_limit    = ttl_proto_q[15:8];
  end

  `IPV4HC_ASSERT(a_idx_range, clk_i, rst_ni, idx_q <= IDLE_INDEX)
  `IPV4HC_ASSERT_IMPL(a_push_room, clk_i, rst_ni, push_o, !q_status_i.full)

endmodule

[rtl/core/ipv4hc_queue.sv]
// ----------------------------------------------------------------------------
// IPv4 header receive check - record queue
// Short queue of parsed records between front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv4_header_receive_check_unit_macros.svh"

module ipv4hc_queue
  import ipv4hc_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hdr_rec_t      push_rec_i,
  input  logic          pop_i,
  output hdr_rec_t      pop_rec_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  hdr_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign pop_rec_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `IPV4HC_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= FullCnt)
  `IPV4HC_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, !status_o.empty)

endmodule

[rtl/core/ipv4hc_back.sv]
// ----------------------------------------------------------------------------
// IPv4 header receive check - back end
// Forms the verdict against the host address and holds the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ipv4_header_receive_check_unit_macros.svh"

module ipv4hc_back
  import ipv4hc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   host_addr_i,
  input  logic [31:0]   host_mask_i,
  input  queue_status_t q_status_i,
  input  hdr_rec_t      rec_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  logic          valid_q;
  verdict_e      verdict_q, verdict_d;
  hdr_rec_t      rec_q;
  logic          dst_match;

  assign pop_o = !q_status_i.empty && (!valid_q || out_ready_i);

  always_comb begin
    dst_match = (rec_i.dst_addr == BCAST_ADDR)
             || (((rec_i.dst_addr & host_mask_i) == (host_addr_i & host_mask_i))
                 && ((rec_i.dst_addr | host_mask_i) == BCAST_ADDR))
             || (rec_i.dst_addr == host_addr_i);
    priority if (!rec_i.fmt_ok) begin
      verdict_d = VERDICT_BAD;
    end else if (!dst_match) begin
      verdict_d = VERDICT_NOT_MINE;
    end else if (rec_i.frag_field != 14'd0) begin
      verdict_d = VERDICT_FRAGMENT;
    end else begin
      verdict_d = VERDICT_DELIVER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict_d;
      rec_q     <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = {5'd0,
                        rec_q.hop_limit,
                        rec_q.frag_field[13],
                        rec_q.frag_field[12:0], 3'd0,
                        rec_q.ident,
                        rec_q.packet_len,
                        rec_q.dst_addr,
                        rec_q.src_addr,
                        rec_q.protocol_num,
                        verdict_q};

  `IPV4HC_ASSERT_IMPL(a_hold_on_stall, clk_i, rst_ni, valid_q && !out_ready_i, !pop_o)

endmodule

[rtl/core/ipv4_header_receive_check_unit.sv]
// ----------------------------------------------------------------------------
// IPv4 header receive check unit
// Takes ten 16-bit header words per packet (first word flagged on tuser)
// and gives one result item per complete header: verdict and parsed fields.
// ----------------------------------------------------------------------------
// Words are taken at one per clock while s_axis_tready is high, header after
// header with no gap; a header's result passes through the record queue and
// the output register after its tenth word. s_axis_tready only drops when
// the ninth word has been taken and the record queue between the word
// counter and the verdict stage is full. Host address and mask must be written
// through the cfg port while no header is in flight; the block does not enforce this.
`timescale 1ns / 1ps

module ipv4_header_receive_check_unit
  import ipv4hc_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // [15:0] header_word
  input  logic                s_axis_tuser,  // [0] first_word
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] verdict, [9:2] protocol_num, [41:10] src_addr, [73:42] dst_addr,
  // [89:74] packet_len, [105:90] ident, [121:106] frag_byte_offset,
  // [122] more_frags, [130:123] hop_limit, [135:131] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic [31:0]   host_addr_q;
  logic [31:0]   host_mask_q;
  logic          push;
  logic          pop;
  hdr_rec_t      push_rec;
  hdr_rec_t      pop_rec;
  queue_status_t q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_addr_q <= 32'd0;
      host_mask_q <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HOST_ADDR: host_addr_q <= cfg_wdata_i;
        REG_HOST_MASK: host_mask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ipv4hc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .word_i     (s_axis_tdata),
    .first_i    (s_axis_tuser),
    .q_status_i (q_status),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  ipv4hc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .pop_rec_o  (pop_rec),
    .status_o   (q_status)
  );

  ipv4hc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .host_addr_i (host_addr_q),
    .host_mask_i (host_mask_q),
    .q_status_i  (q_status),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
